[hdl/grca_pkg.sv]
// Shared types and constants for the ARGB horizontal Gaussian row filter.
// No dependencies; imported by every module of the block.
package grca_pkg;

  localparam int MAX_RADIUS    = 6;
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int COEF_BITS     = 16;

  localparam int NUM_TAPS    = 2 * MAX_RADIUS + 1;
  localparam int PIX_BITS    = 32;
  localparam int CH_BITS     = 8;
  localparam int NUM_CH      = PIX_BITS / CH_BITS;
  localparam int WIN_BITS    = NUM_TAPS * PIX_BITS;
  localparam int RAD_BITS    = 3;
  localparam int COL_BITS    = 13;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int AGE_BITS    = $clog2(NUM_TAPS);
  localparam int PROD_BITS   = CH_BITS + COEF_W;
  localparam int GRP_TAPS    = 4;
  localparam int NUM_GRP     = (NUM_TAPS + GRP_TAPS - 1) / GRP_TAPS;
  localparam int GRP_BITS    = PROD_BITS + $clog2(GRP_TAPS);
  localparam int SUM_BITS    = PROD_BITS + $clog2(NUM_TAPS);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS    = 3'd0,
    REG_ROW_WIDTH = 3'd1,
    REG_TAPS_0_3  = 3'd2,
    REG_TAPS_4_7  = 3'd3,
    REG_TAPS_8_11 = 3'd4,
    REG_TAP_12    = 3'd5
  } cfg_reg_t;

  typedef logic [NUM_TAPS-1:0][COEF_W-1:0] coef_vec_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] radius;
    logic [COL_BITS-1:0] last_col;
  } geom_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] window;
    logic [AGE_BITS-1:0] col;
    logic [RAD_BITS-1:0] radius;
    logic [RAD_BITS-1:0] d_start;
    logic                last;
  } job_t;

endpackage

[hdl/grca_front.sv]
// Front end: takes pixels, keeps the pixel window and column, and queues filter jobs.
// Depends on grca_pkg.
module grca_front (
  input  logic           clk,
  input  logic           rst_n,
  input  grca_pkg::geom_t geom,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_argb_in,
  input  logic           q_ready,
  output logic           q_push,
  output grca_pkg::job_t q_job
);
  import grca_pkg::*;

  logic [WIN_BITS-1:0] window_r, window_nxt;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic                accept, last, produce;
  logic [COL_BITS-1:0] rad_ext;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign rad_ext  = COL_BITS'(geom.radius);
  assign last     = (col_r >= geom.last_col);
  assign produce  = last || (col_r >= rad_ext);
  assign window_nxt = {in_argb_in, window_r[WIN_BITS-1:PIX_BITS]};

  always_comb begin
    q_job.window = window_nxt;
    q_job.col    = (col_r > COL_BITS'(NUM_TAPS - 1)) ? AGE_BITS'(NUM_TAPS - 1)
                                                      : col_r[AGE_BITS-1:0];
    q_job.radius = geom.radius;
    q_job.last   = last;
    if (last && (col_r < rad_ext)) begin
      q_job.d_start = col_r[RAD_BITS-1:0];
    end else begin
      q_job.d_start = geom.radius;
    end
    q_push = accept && produce;
  end

  always_comb begin
    col_nxt = col_r;
    if (accept) begin
      col_nxt = last ? '0 : col_r + COL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_r <= window_nxt;
    end
  end

endmodule

[hdl/grca_queue.sv]
// Two-entry job queue between the front end and the filter datapath.
// Depends on grca_pkg.
module grca_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  grca_pkg::job_t push_job,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output grca_pkg::job_t head
);
  import grca_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign ready      = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hdl/grca_back.sv]
// Filter datapath: issues one output column per unstalled cycle from queued
// jobs into tap select, multiply, group and final sum stages. Uses grca_pkg.
module grca_back (
  input  logic               clk,
  input  logic               rst_n,
  input  grca_pkg::coef_vec_t coef,
  input  logic               head_valid,
  input  grca_pkg::job_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_argb_out,
  output logic               out_row_end
);
  import grca_pkg::*;

  logic                busy_r, busy_nxt;
  logic [RAD_BITS-1:0] d_r, d_nxt, d_cur;
  logic                issue, job_done;
  logic [AGE_BITS-1:0] span, shamt;
  logic [AGE_BITS-1:0] two_r;
  logic [WIN_BITS-1:0] shifted;

  logic                                v1_r, v2_r, v3_r, v4_r;
  logic                                end1_r, end2_r, end3_r, end4_r;
  logic                                en1, en2, en3, en4;
  logic [NUM_TAPS-1:0][PIX_BITS-1:0]   tap_nxt, tap_r;
  logic [NUM_TAPS-1:0][NUM_CH-1:0][PROD_BITS-1:0] prod_r;
  logic [NUM_GRP-1:0][NUM_CH-1:0][GRP_BITS-1:0]   grp_nxt, grp_r;
  logic [NUM_CH-1:0][SUM_BITS-1:0]     sum;
  logic [31:0]                         argb_nxt, argb_r;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign d_cur    = busy_r ? d_r : head.d_start;
  assign issue    = head_valid && en1;
  assign job_done = (d_cur == '0) || !head.last;
  assign pop      = issue && job_done;

  always_comb begin
    busy_nxt = busy_r;
    d_nxt    = d_r;
    if (issue) begin
      busy_nxt = !job_done;
      d_nxt    = d_cur - RAD_BITS'(1);
    end
  end

  assign span    = AGE_BITS'(d_cur) + AGE_BITS'(head.radius);
  assign shamt   = AGE_BITS'(NUM_TAPS - 1) - span;
  assign two_r   = {head.radius, 1'b0};
  assign shifted = head.window >> (shamt * PIX_BITS);

  always_comb begin
    for (int t = 0; t < NUM_TAPS; t++) begin
      if ((AGE_BITS'(t) <= two_r) && (AGE_BITS'(t) <= span) &&
          ((span - AGE_BITS'(t)) <= head.col)) begin
        tap_nxt[t] = shifted[t*PIX_BITS +: PIX_BITS];
      end else begin
        tap_nxt[t] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        grp_nxt[g][c] = '0;
        for (int k = 0; k < GRP_TAPS; k++) begin
          if (g * GRP_TAPS + k < NUM_TAPS) begin
            grp_nxt[g][c] = grp_nxt[g][c] + GRP_BITS'(prod_r[g*GRP_TAPS+k][c]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
        sum[c] = sum[c] + SUM_BITS'(grp_r[g][c]);
      end
      argb_nxt[c*CH_BITS +: CH_BITS] = sum[c][COEF_BITS +: CH_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      d_r    <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      d_r    <= d_nxt;
      if (en1) v1_r <= issue;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tap_r  <= tap_nxt;
      end1_r <= head.last && (d_cur == '0);
    end
    if (en2) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          prod_r[t][c] <= tap_r[t][c*CH_BITS +: CH_BITS] * coef[t];
        end
      end
      end2_r <= end1_r;
    end
    if (en3) begin
      grp_r  <= grp_nxt;
      end3_r <= end2_r;
    end
    if (en4) begin
      argb_r <= argb_nxt;
      end4_r <= end3_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_argb_out = argb_r;
  assign out_row_end  = end4_r;

endmodule

[hdl/gaussian_row_convolution_argb_core.sv]
// Top level of the ARGB horizontal Gaussian row filter: configuration registers,
// front end, job queue and filter datapath. Depends on grca_pkg and the grca_* modules.
//
// Takes one ARGB pixel per clock while the job queue has room and filters each
// channel with a 2*radius+1 tap Q0.16 kernel along the row; taps outside the row
// are dropped. Result for column p leaves after input pixel p+radius arrives; the
// last pixel of a row releases the remaining results (up to radius+1), so a row of
// W pixels takes exactly W issue slots in total, i.e. one result per clock on
// average without output back-pressure. Inputs stall whenever the two-entry job
// queue is full: under output back-pressure, or when a row-end flush is followed
// by rows too short to cover it. Each result passes the registered tap select,
// multiply, group sum and final sum/output register stages. Configuration
// writes are always accepted and take effect at once.
module gaussian_row_convolution_argb_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_argb_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_argb_out,
  output logic        out_row_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [grca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grca_pkg::CFG_W-1:0]     cfg_data
);
  import grca_pkg::*;

  logic [RAD_BITS-1:0] radius_r;
  logic [COL_BITS-1:0] row_width_r;
  coef_vec_t           coef_r;
  geom_t               geom;
  logic                q_push, q_ready, q_pop, q_head_valid;
  job_t                q_job, q_head;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RAD_BITS'(2);
      row_width_r <= COL_BITS'(640);
      coef_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:    radius_r      <= cfg_data[RAD_BITS-1:0];
        REG_ROW_WIDTH: row_width_r   <= cfg_data[COL_BITS-1:0];
        REG_TAPS_0_3:  coef_r[3:0]   <= cfg_data;
        REG_TAPS_4_7:  coef_r[7:4]   <= cfg_data;
        REG_TAPS_8_11: coef_r[11:8]  <= cfg_data;
        REG_TAP_12:    coef_r[12]    <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.radius = (radius_r > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_r;
    if (row_width_r == '0) begin
      geom.last_col = '0;
    end else if (row_width_r > COL_BITS'(MAX_ROW_WIDTH)) begin
      geom.last_col = COL_BITS'(MAX_ROW_WIDTH - 1);
    end else begin
      geom.last_col = row_width_r - COL_BITS'(1);
    end
  end

  grca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_argb_in(in_argb_in),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  grca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .ready     (q_ready),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  grca_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef_r),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_argb_out(out_argb_out),
    .out_row_end (out_row_end)
  );

endmodule

[bench/gaussian_row_convolution_argb_core_tb.sv]
// Testbench for gaussian_row_convolution_argb_core: directed and random ARGB rows
// checked against a built-in row filter predictor. Depends on grca_pkg and the RTL.
module gaussian_row_convolution_argb_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grca_pkg::*;

  localparam int RANDOM_ITEMS   = 220;
  localparam int QUIET_ITEMS    = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [31:0] argb;
    logic        row_end;
  } blur_result_t;

  class blur_scoreboard;
    logic [RAD_BITS-1:0] radius_q = 3'd2;
    logic [COL_BITS-1:0] width_q  = 13'd640;
    logic [COEF_W-1:0]   coef_q[NUM_TAPS];
    logic [31:0]         window_q[NUM_TAPS];
    int                  col_q  = 0;
    int                  errors = 0;
    blur_result_t        expected_pixels[$];

    function new();
      foreach (coef_q[i]) coef_q[i] = '0;
      foreach (window_q[i]) window_q[i] = '0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] d);
      case (idx)
        REG_RADIUS: radius_q = d[RAD_BITS-1:0];
        REG_ROW_WIDTH: width_q = d[COL_BITS-1:0];
        REG_TAPS_0_3, REG_TAPS_4_7, REG_TAPS_8_11: begin
          for (int k = 0; k < 4; k++)
            coef_q[(int'(idx) - int'(REG_TAPS_0_3)) * 4 + k] = d[16*k +: 16];
        end
        REG_TAP_12: coef_q[12] = d[15:0];
        default: ;
      endcase
    endfunction

    // filtered column p while columns 0..c of the row are held
    function logic [31:0] blur_at(int p, int c, int r);
      logic [31:0] acc[4];
      logic [31:0] res;
      logic [31:0] px;
      int q;
      int age;
      for (int ch = 0; ch < 4; ch++) acc[ch] = '0;
      for (int t = 0; t <= 2 * r && t < NUM_TAPS; t++) begin
        q = p - r + t;
        if (q < 0 || q > c) continue;
        age = c - q;
        if (age >= NUM_TAPS) continue;
        px = window_q[age];
        for (int ch = 0; ch < 4; ch++) acc[ch] += px[8*ch +: 8] * coef_q[t];
      end
      for (int ch = 0; ch < 4; ch++) res[8*ch +: 8] = acc[ch][COEF_BITS +: 8];
      return res;
    endfunction

    function void note_pixel(logic [31:0] pix);
      int r;
      int w;
      int c;
      int first;
      r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
      w = (width_q == 0) ? 1 : ((width_q > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_q));
      c = col_q;
      for (int i = NUM_TAPS - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = pix;
      if (c >= w - 1) begin
        first = (c >= r) ? c - r : 0;
        for (int p = first; p <= c; p++)
          expected_pixels.push_back(blur_result_t'{blur_at(p, c, r), p == c});
        col_q = 0;
      end else begin
        if (c >= r) expected_pixels.push_back(blur_result_t'{blur_at(c - r, c, r), 1'b0});
        col_q = (c + 1) & 13'h1fff;
      end
    endfunction

    function void check_result(logic [31:0] argb, logic row_end);
      blur_result_t exp_r;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: argb_out=%h row_end=%b", argb, row_end);
        errors++;
        return;
      end
      exp_r = expected_pixels.pop_front();
      if (argb !== exp_r.argb) begin
        $error("argb_out mismatch: expected %h, actual %h", exp_r.argb, argb);
        errors++;
      end
      if (row_end !== exp_r.row_end) begin
        $error("row_end mismatch: expected %b, actual %b", exp_r.row_end, row_end);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [31:0]          in_argb_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          out_argb_out;
  logic                 out_row_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  blur_scoreboard sb = new();
  bit idling        = 1'b1;
  bit long_hold_req = 1'b0;
  bit pressure_done = 1'b0;
  int sent          = 0;
  int stall_cycles  = 0;

  gaussian_row_convolution_argb_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_argb_in   (in_argb_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_argb_out (out_argb_out),
    .out_row_end  (out_row_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_pixel(in_argb_in);
      if (out_valid && out_ready) sb.check_result(out_argb_out, out_row_end);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result sink: random back-pressure, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'hffff_ffff;
      1: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_taps();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = {4{16'hffff}};
      default: begin
        for (int k = 0; k < 4; k++) v[16*k +: 16] = 16'($urandom_range(0, 16'h1400));
      end
    endcase
    return v;
  endfunction

  function automatic int rand_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(17, 48);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(logic [2:0] rad, logic [12:0] width, logic [63:0] t03,
                             logic [63:0] t47, logic [63:0] t811, logic [15:0] t12);
    cfg_write(REG_RADIUS, 64'(rad));
    cfg_write(REG_ROW_WIDTH, 64'(width));
    cfg_write(REG_TAPS_0_3, t03);
    cfg_write(REG_TAPS_4_7, t47);
    cfg_write(REG_TAPS_8_11, t811);
    cfg_write(REG_TAP_12, 64'(t12));
    cfg_release();
  endtask

  task automatic send_pixel(logic [31:0] pix);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_argb_in <= pix;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_row(int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // drop valid and let the monitor note the last transfer before checking pending
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int start;
    int w;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_argb_in <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_RADIUS;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // radius zero, one-pixel rows
    program_all(3'd0, 13'd1, 64'h0000_0000_0000_ffff, '0, '0, 16'h0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    drain();

    // radius clamped to max, zero width, then a row narrower than the kernel
    program_all(3'd7, 13'd0, {4{16'hffff}}, {4{16'hffff}}, {4{16'hffff}}, 16'hffff);
    send_pixel(32'hffff_ffff);
    drain();
    cfg_write(REG_ROW_WIDTH, 64'd3);
    cfg_release();
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0102_0304);
    send_pixel(32'h8080_8080);
    drain();

    program_all(3'd2, 13'd5, 64'h1000_2000_4000_2000, 64'h0000_0000_0000_1000, '0, 16'h0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'h7f80_ff01);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h1234_5678);
    drain();

    // width clamped, then lowered mid-row so the next pixel ends the row
    cfg_write(REG_ROW_WIDTH, 64'd8191);
    cfg_release();
    send_row(3);
    drain();
    cfg_write(REG_ROW_WIDTH, 64'd2);
    cfg_release();
    send_row(1);
    drain();

    // radius change mid-row
    program_all(3'd1, 13'd6, rand_taps(), rand_taps(), rand_taps(), 16'($urandom));
    send_row(3);
    drain();
    cfg_write(REG_RADIUS, 64'd3);
    cfg_release();
    send_row(3);
    drain();

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      idling = (sent - start) < RANDOM_ITEMS - QUIET_ITEMS;
      if (!pressure_done && sent - start >= 60) begin
        pressure_done = 1'b1;
        program_all(3'd6, 13'd7, rand_taps(), rand_taps(), rand_taps(), 16'($urandom));
        idling = 1'b0;
        long_hold_req = 1'b1;
        send_row(28);
        drain();
        continue;
      end
      w = rand_width();
      program_all(3'($urandom_range(0, 7)), 13'(w), rand_taps(), rand_taps(), rand_taps(),
                  16'($urandom));
      if (w == 0) w = 1;
      repeat ($urandom_range(1, 3)) send_row(w);
      if ($urandom_range(0, 3) == 0) send_row($urandom_range(1, w));
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
